@@ src/y2rgb_pkg.sv @@
// y2rgb_pkg: types, constants and helper functions for the yuyv to rgb converter
// no dependencies; imported by yuyv_to_rgb_converter_top and its testbench
package y2rgb_pkg;

    // configuration register widths and indexes
    localparam int LINE_WIDTH_W = 13;
    localparam int MASK_LEVEL_W = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_LEVEL = 1'b1;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd720;
    localparam logic [MASK_LEVEL_W-1:0] MASK_LEVEL_RESET = 9'd255;

    // default longest line
    localparam int MAX_LINE_DEFAULT = 4096;

    // fixed-point arithmetic: coefficients scaled by 2^16
    localparam int PROD_W = 27;
    localparam int SUM_W  = 28;

    localparam logic signed [PROD_W-1:0] K_Y  = 27'sd76310;
    localparam logic signed [PROD_W-1:0] K_RV = 27'sd104635;
    localparam logic signed [PROD_W-1:0] K_GU = -27'sd25690;
    localparam logic signed [PROD_W-1:0] K_GV = -27'sd53294;
    localparam logic signed [PROD_W-1:0] K_BU = 27'sd132278;

    localparam logic signed [SUM_W-1:0] SUM_TOP    = 28'sh0FFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_BOTTOM = 28'sh000FFFF;

    // offsets applied to the raw bytes
    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_CENTRE = 9'sd128;

    // input item: one pixel with the chroma bytes of its group
    typedef struct packed {
        logic [7:0] luma_byte;
        logic [7:0] chroma_first;
        logic [7:0] chroma_second;
    } pixel_in_t;

    // result item: one rgb pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_out_t;

    // clamp a scaled sum to an 8-bit component
    function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] x);
        logic [7:0] c;
        if (x > SUM_TOP)
        begin
            c = 8'hFF;
        end
        else if (x <= SUM_BOTTOM)
        begin
            c = 8'h00;
        end
        else
        begin
            c = x[23:16];
        end
        return c;
    endfunction

endpackage

@@ src/yuyv_to_rgb_converter_top.sv @@
// yuyv_to_rgb_converter_top: yuyv pixel stream to 8-bit rgb, bt.601 fixed point
// depends on y2rgb_pkg for item types, coefficients and the clamp function
//
// Usage
//   Input channel in_valid / in_stall / in_item carries one pixel per item: its
//   luma byte and the two chroma bytes of its yuyv group. Output channel
//   out_valid / out_stall / out_item carries one rgb item for every input item,
//   in order. An item moves at a rising edge where valid is high and stall low.
//   Configuration: cfg_write with cfg_index selects line_width (index 0) or
//   mask_level (index 1); write only while the block is idle.
//   Path: an accepted item lands in the input stage (luma offset, chroma
//   latch) and then passes through the constant multiplies, the sums and the
//   clamp into the output register, which drives out_valid and out_item.
//   Throughput is one item per clock while out_stall stays low; each stage
//   holds one item and moves on whenever the stage after it is empty or moving.
//   Reset clears both stages, the chroma phase (load on the first pixel), the
//   column count and line parity, and loads line_width 720 and mask_level 255.
//   When the receiver stalls, the output item holds and the input stage fills
//   up; in_stall rises only once the input stage is full and cannot move.
module yuyv_to_rgb_converter_top
    import y2rgb_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pixel_in_t              in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rgb_out_t               out_item
);

    localparam int MAX_W = $clog2(MAX_LINE + 1);
    localparam int WW    = (MAX_W > LINE_WIDTH_W) ? MAX_W : LINE_WIDTH_W;
    localparam int CW    = $clog2(MAX_LINE);

    // configuration registers
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [MASK_LEVEL_W-1:0] mask_level_reg;

    // stream state
    logic          chroma_phase_reg, chroma_phase_next;
    logic [CW-1:0] column_count_reg, column_count_next;
    logic          line_odd_reg, line_odd_next;
    logic [7:0]    held_u_reg, held_u_next;
    logic [7:0]    held_v_reg, held_v_next;

    // pipeline registers
    logic                     s1_valid_reg;
    logic signed [8:0]        s1_luma_reg, s1_luma_next;
    logic signed [8:0]        s1_u_reg, s1_u_next;
    logic signed [8:0]        s1_v_reg, s1_v_next;
    logic                     out_valid_reg;
    rgb_out_t                 out_item_reg, out_item_next;

    logic          in_accept;
    logic          s1_ready, out_ready;
    logic [WW-1:0] width_ext, eff_width, column_plus;
    logic          swap_chroma;
    logic [7:0]    load_u, load_v;
    logic signed [8:0] luma_off;
    logic signed [PROD_W-1:0] prod_ly, prod_rv, prod_gu, prod_gv, prod_bu;
    logic signed [SUM_W-1:0] sum_r, sum_g, sum_b;

    // handshake: each stage moves when the next is empty or moving
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            mask_level_reg <= MASK_LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LINE_WIDTH_W-1:0];
                REG_MASK_LEVEL: mask_level_reg <= cfg_data[MASK_LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective line width, kept within one and the longest line
    always_comb
    begin
        width_ext = WW'(line_width_reg);
        if (width_ext == '0)
        begin
            eff_width = WW'(1);
        end
        else if (width_ext > WW'(MAX_LINE))
        begin
            eff_width = WW'(MAX_LINE);
        end
        else
        begin
            eff_width = width_ext;
        end
    end

    // luma offset with the mask level bumped out of the way
    always_comb
    begin
        luma_off = $signed({1'b0, in_item.luma_byte}) - LUMA_OFFSET;
        if (luma_off == $signed(mask_level_reg))
        begin
            s1_luma_next = luma_off + 9'sd1;
        end
        else
        begin
            s1_luma_next = luma_off;
        end
    end

    // chroma latch on alternate pixels, swapped on odd lines of odd width
    always_comb
    begin
        swap_chroma = eff_width[0] && line_odd_reg;
        load_u      = swap_chroma ? in_item.chroma_second : in_item.chroma_first;
        load_v      = swap_chroma ? in_item.chroma_first : in_item.chroma_second;
        held_u_next = chroma_phase_reg ? load_u : held_u_reg;
        held_v_next = chroma_phase_reg ? load_v : held_v_reg;
        s1_u_next   = $signed({1'b0, held_u_next}) - CHROMA_CENTRE;
        s1_v_next   = $signed({1'b0, held_v_next}) - CHROMA_CENTRE;
        chroma_phase_next = !chroma_phase_reg;
    end

    // column count and line parity
    always_comb
    begin
        column_plus = WW'(column_count_reg) + WW'(1);
        if (column_plus >= eff_width)
        begin
            column_count_next = '0;
            line_odd_next     = !line_odd_reg;
        end
        else
        begin
            column_count_next = column_plus[CW-1:0];
            line_odd_next     = line_odd_reg;
        end
    end

    // stream state advances on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_phase_reg <= 1'b1;
            column_count_reg <= '0;
            line_odd_reg     <= 1'b0;
            held_u_reg       <= '0;
            held_v_reg       <= '0;
        end
        else if (in_accept)
        begin
            chroma_phase_reg <= chroma_phase_next;
            column_count_reg <= column_count_next;
            line_odd_reg     <= line_odd_next;
            held_u_reg       <= held_u_next;
            held_v_reg       <= held_v_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_luma_reg <= s1_luma_next;
            s1_u_reg    <= s1_u_next;
            s1_v_reg    <= s1_v_next;
        end
    end

    // constant products, sums and clamp
    always_comb
    begin
        prod_ly = PROD_W'(s1_luma_reg) * K_Y;
        prod_rv = PROD_W'(s1_v_reg) * K_RV;
        prod_gu = PROD_W'(s1_u_reg) * K_GU;
        prod_gv = PROD_W'(s1_v_reg) * K_GV;
        prod_bu = PROD_W'(s1_u_reg) * K_BU;
        sum_r = SUM_W'(prod_ly) + SUM_W'(prod_rv);
        sum_g = SUM_W'(prod_ly) + SUM_W'(prod_gu) + SUM_W'(prod_gv);
        sum_b = SUM_W'(prod_ly) + SUM_W'(prod_bu);
        out_item_next.red   = clamp_sum(sum_r);
        out_item_next.green = clamp_sum(sum_g);
        out_item_next.blue  = clamp_sum(sum_b);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // chroma phase leaves the load phase after every accepted pixel
    a_phase_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && chroma_phase_reg |=> !chroma_phase_reg)
        else $error("chroma phase did not toggle");

    // line parity only moves with an accepted pixel
    a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(line_odd_reg) && $stable(column_count_reg))
        else $error("line position changed without an item");

    // input stalls only with a full input stage
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

    // a blocked input stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(s1_u_reg)
            && $stable(s1_v_reg) && $stable(s1_luma_reg))
        else $error("input stage item lost while blocked");

endmodule

@@ test/tb_yuyv_to_rgb_converter_top.sv @@
`timescale 1ns / 100ps
// tb_yuyv_to_rgb_converter_top: self-checking bench for the yuyv to rgb converter
// a directed table, then randomised phases; each rgb item is checked against a local predictor or a table colour
// depends on y2rgb_pkg and yuyv_to_rgb_converter_top
module tb_yuyv_to_rgb_converter_top;
    import y2rgb_pkg::*;

    localparam int PIPE_DEPTH      = 2;
    localparam int HOLD_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES          = 8;

    // colour matrix, scaled by 2^16
    localparam longint C_LUMA  = 76310;
    localparam longint C_RED_V = 104635;
    localparam longint C_GRN_U = -25690;
    localparam longint C_GRN_V = -53294;
    localparam longint C_BLU_U = 132278;
    localparam longint SUM_CEIL  = 16777215;
    localparam longint SUM_FLOOR = 65535;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // one line of the directed table
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        pixel_in_t              px;
        logic                   typed;
        rgb_out_t               rgb;
    } plan_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    pixel_in_t              in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    rgb_out_t               out_item;

    // predictor copy of the registers and pixel state
    logic [LINE_WIDTH_W-1:0]        pv_width;
    logic signed [MASK_LEVEL_W-1:0] pv_mask;
    logic                           pv_phase;
    int                             pv_col;
    logic                           pv_line_odd;
    logic [7:0]                     pv_u;
    logic [7:0]                     pv_v;

    rgb_out_t rgb_expected[$];

    int fail_count     = 0;
    int idle_run       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    yuyv_to_rgb_converter_top #(
        .MAX_LINE (MAX_LINE_DEFAULT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #10 clk = ~clk;

    // table row builders
    function automatic plan_row_t pix(input logic [7:0] y, input logic [7:0] u,
                                      input logic [7:0] v);
        plan_row_t r;
        r = '0;
        r.kind = ROW_PIXEL;
        r.px.luma_byte = y;
        r.px.chroma_first = u;
        r.px.chroma_second = v;
        return r;
    endfunction

    function automatic plan_row_t pix_rgb(input logic [7:0] y, input logic [7:0] u,
                                          input logic [7:0] v, input logic [23:0] rgb);
        plan_row_t r;
        r = pix(y, u, v);
        r.typed = 1'b1;
        r.rgb = rgb;
        return r;
    endfunction

    function automatic plan_row_t reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // fixed-point sum to an 8-bit component
    function automatic logic [7:0] squash_sum(input longint s);
        if (s > SUM_CEIL)
        begin
            return 8'd255;
        end
        if (s <= SUM_FLOOR)
        begin
            return 8'd0;
        end
        return s[23:16];
    endfunction

    // colour of one pixel; advances chroma phase, column and line parity
    function automatic rgb_out_t predict_rgb(input pixel_in_t px);
        int       span;
        int       y_off;
        int       cu;
        int       cv;
        longint   ly;
        rgb_out_t rgb;
        span = int'(pv_width);
        if (span == 0)
        begin
            span = 1;
        end
        else if (span > MAX_LINE_DEFAULT)
        begin
            span = MAX_LINE_DEFAULT;
        end
        y_off = int'(px.luma_byte) - 16;
        // reserved mask level: step the luma past it
        if (y_off != 255 && y_off == int'(pv_mask))
        begin
            y_off++;
        end
        ly = longint'(y_off) * C_LUMA;
        // chroma loads on alternate pixels, swapped on odd lines of odd width
        if (pv_phase)
        begin
            if (span % 2 == 1 && pv_line_odd)
            begin
                pv_u = px.chroma_second;
                pv_v = px.chroma_first;
            end
            else
            begin
                pv_u = px.chroma_first;
                pv_v = px.chroma_second;
            end
        end
        cu = int'(pv_u) - 128;
        cv = int'(pv_v) - 128;
        rgb.red   = squash_sum(C_RED_V * cv + ly);
        rgb.green = squash_sum(C_GRN_U * cu + C_GRN_V * cv + ly);
        rgb.blue  = squash_sum(C_BLU_U * cu + ly);
        pv_phase = ~pv_phase;
        if (pv_col + 1 >= span)
        begin
            pv_col = 0;
            pv_line_odd = ~pv_line_odd;
        end
        else
        begin
            pv_col++;
        end
        return rgb;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // offer one pixel item, wait for it to go in, then queue its colour
    task automatic offer_pixel(input pixel_in_t px, input logic typed, input rgb_out_t typed_rgb);
        rgb_out_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= px;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        want = predict_rgb(px);
        if (typed)
        begin
            want = typed_rgb;
        end
        rgb_expected.push_back(want);
    endtask

    // let every queued colour come out, then let the clock run with the input idle
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (rgb_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_LINE_WIDTH)
        begin
            pv_width = data[LINE_WIDTH_W-1:0];
        end
        else
        begin
            pv_mask = data[MASK_LEVEL_W-1:0];
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each rgb item with the oldest predicted colour
    always @(posedge clk)
    begin : check_rgb
        rgb_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rgb_expected.size() == 0)
            begin
                flag_mismatch($sformatf("rgb item %h with nothing predicted", out_item));
            end
            else
            begin
                want = rgb_expected.pop_front();
                if (out_item.red != want.red)
                begin
                    flag_mismatch($sformatf("red %h, predicted %h", out_item.red, want.red));
                end
                if (out_item.green != want.green)
                begin
                    flag_mismatch($sformatf("green %h, predicted %h",
                                            out_item.green, want.green));
                end
                if (out_item.blue != want.blue)
                begin
                    flag_mismatch($sformatf("blue %h, predicted %h", out_item.blue, want.blue));
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_run <= 0;
        end
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_run <= idle_run + 1;
        end
    end

    initial
    begin : stimulus
        plan_row_t plan[$];
        pixel_in_t px;
        int        span_pick[PHASES];
        int        mask_pick[PHASES];
        int        luma_pick;
        int        roll;

        // directed table
        plan = '{
            // full-scale grey saturates high; chroma loads on the first pixel after reset
            pix_rgb(8'd255, 8'd128, 8'd128, 24'hFFFFFF),
            // below black clamps low; chroma not loaded on this phase
            pix_rgb(8'd0, 8'd17, 8'd230, 24'h000000),
            pix(8'd16, 8'd0, 8'd255),
            pix(8'd200, 8'd255, 8'd0),
            pix(8'd128, 8'd255, 8'd0),
            pix(8'd235, 8'd0, 8'd0),
            // mask at zero: black luma bumped to one step
            reg_write(REG_MASK_LEVEL, 13'd0),
            pix_rgb(8'd16, 8'd128, 8'd128, 24'h010101),
            pix_rgb(8'd16, 8'd0, 8'd0, 24'h010101),
            // lowest mask level
            reg_write(REG_MASK_LEVEL, CFG_DATA_W'(-16)),
            pix_rgb(8'd0, 8'd128, 8'd128, 24'h000000),
            pix(8'd1, 8'd90, 8'd60),
            reg_write(REG_MASK_LEVEL, 13'd255),
            // odd width set mid-line, column already past it: chroma swap on odd lines
            reg_write(REG_LINE_WIDTH, 13'd3),
            pix(8'd81, 8'd90, 8'd240),
            pix(8'd145, 8'd54, 8'd34),
            pix(8'd41, 8'd240, 8'd110),
            pix(8'd210, 8'd16, 8'd146),
            pix(8'd170, 8'd166, 8'd16),
            pix(8'd107, 8'd202, 8'd222),
            pix(8'd235, 8'd128, 8'd64),
            pix(8'd60, 8'd33, 8'd200),
            pix(8'd128, 8'd77, 8'd177),
            pix(8'd16, 8'd250, 8'd5),
            // zero width behaves as one pixel per line
            reg_write(REG_LINE_WIDTH, 13'd0),
            pix(8'd180, 8'd44, 8'd99),
            pix(8'd99, 8'd200, 8'd12),
            // width beyond the longest line
            reg_write(REG_LINE_WIDTH, 13'h1FFF),
            pix(8'd255, 8'd255, 8'd255),
            pix(8'd0, 8'd0, 8'd0)
        };

        span_pick = '{1, 7, 0, 4096, 8191, 2, 0, 0};
        mask_pick = '{-16, 255, 239, 0, 100, -1, 0, 0};
        span_pick[6] = int'($urandom_range(8191));
        span_pick[7] = int'($urandom_range(12, 1));
        mask_pick[6] = int'($urandom_range(255)) - 16;
        mask_pick[7] = int'($urandom_range(255)) - 16;

        // predictor at reset
        pv_width = LINE_WIDTH_RESET;
        pv_mask = MASK_LEVEL_RESET;
        pv_phase = 1'b1;
        pv_col = 0;
        pv_line_odd = 1'b0;
        pv_u = 8'd0;
        pv_v = 8'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain_pipe();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                offer_pixel(plan[i].px, plan[i].typed, plan[i].rgb);
            end
        end

        // random phases, each with its own settings; the idling pattern repeats every four phases
        for (int p = 0; p < PHASES; p++)
        begin
            drain_pipe();
            write_reg(REG_LINE_WIDTH, CFG_DATA_W'(span_pick[p]));
            write_reg(REG_MASK_LEVEL, CFG_DATA_W'(mask_pick[p]));
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 47;
                end
                default:
                begin
                    send_idle_pct = 7;
                    recv_stall_pct <= 7;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while items keep coming
                if (p == 0 && n == 10)
                begin
                    hold_asked <= hold_asked + 1;
                end
                px.luma_byte = 8'($urandom_range(255));
                px.chroma_first = 8'($urandom_range(255));
                px.chroma_second = 8'($urandom_range(255));
                luma_pick = int'(pv_mask) + 16;
                roll = int'($urandom_range(99));
                if (roll < 20 && luma_pick >= 0 && luma_pick <= 255)
                begin
                    px.luma_byte = luma_pick[7:0];
                end
                else if (roll < 35)
                begin
                    px.chroma_first = $urandom_range(1) ? 8'hFF : 8'h00;
                    px.chroma_second = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                offer_pixel(px, 1'b0, '0);
            end
        end

        drain_pipe();
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
